>>> rtl/msl_pkg.sv
// Shared constants and types for the mip surface locator.
// No dependencies; imported by mip_surface_locator and msl_size_gen.
`timescale 1ns / 1ps
`default_nettype none

package msl_pkg;

	localparam int ADDR_BITS     = 32;
	localparam int MAX_LEVELS    = 15;
	// face stride alignment, kept as a power of two
	localparam int FACE_ALIGN_LG = 7;
	localparam int FACE_ALIGN    = 1 << FACE_ALIGN_LG;
	localparam int CUBE_FACES    = 6;
	localparam int BLOCK_DIV_LG  = 2;
	localparam int BLOCK_MIN     = 4;

	localparam int DIM_W  = 13;
	localparam int DEP_W  = 10;
	localparam int PIT_W  = 16;
	localparam int LVL_W  = 4;
	localparam int FACE_W = 3;
	localparam int PH_W   = PIT_W + DIM_W;
	localparam int PROD_W = PH_W + DEP_W;

	typedef struct packed {
		logic             start;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [DEP_W-1:0] depth;
		logic [PIT_W-1:0] pitch;
		logic [LVL_W-1:0] levels;
		logic             comp;
	} msl_size_cmd_t;

	typedef struct packed {
		logic                 valid;
		logic                 last;
		logic [LVL_W-1:0]     idx;
		logic [ADDR_BITS-1:0] size;
	} msl_size_rsp_t;

endpackage

`default_nettype wire

>>> rtl/mip_surface_locator.sv
// Top level of the mip surface locator: sequencer, shared adder, level size table.
// Depends on msl_pkg and msl_size_gen.
//
// Usage: one lookup transaction in on s_axis, one result transaction out on m_axis.
// s_axis_tdata carries the texture description and surface address, s_axis_tuser
// the cube and compressed flags. m_axis_tuser[0] is found, m_axis_tdata holds the
// level and face (both zero when not found).
// Sequence from input transaction to result: if the surface sits at the texture base
// or the level count is zero, the lookup goes straight to its done state; otherwise
// it sizes every level (one multiply pair per level), computes the face stride, then
// walks the levels and changes face on the shared adder, and ends in the done state.
// s_axis_tready is high only while the sequencer is idle; one lookup at a time,
// so the next lookup is taken no earlier than the cycle its predecessor's
// result can first leave.
// The result sits in an output register, so a new lookup is taken while a
// result waits; a finished lookup holds in its done state until that
// register frees up.
// Reset clears the sequencer and output valid; no memory needs clearing.
`timescale 1ns / 1ps
`default_nettype none

module mip_surface_locator
	import msl_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// texture_base[31:0], surface_addr[63:32], base_width[76:64], base_height[89:77],
	// base_depth[99:90], base_pitch[115:100], level_count[119:116]
	input  wire  [119:0] s_axis_tdata,
	// is_cube[0], is_compressed[1]
	input  wire  [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// level_index[3:0], face_index[6:4], zero[7]
	output logic [7:0]   m_axis_tdata,
	// found[0]
	output logic         m_axis_tuser
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SIZE   = 6'b000010,
		ST_STRIDE = 6'b000100,
		ST_WALK   = 6'b001000,
		ST_NEXTF  = 6'b010000,
		ST_DONE   = 6'b100000
	} st_t;

	st_t                  state_q;
	logic [ADDR_BITS-1:0] base_q, surf_q, total_q, stride_q, addr_q, face_q;
	logic [ADDR_BITS-1:0] size_mem [MAX_LEVELS];
	logic [LVL_W-1:0]     levels_q, lvl_q;
	logic [FACE_W-1:0]    faces_q, fidx_q;
	logic                 found_q;
	logic                 out_valid_q, out_found_q;
	logic [LVL_W-1:0]     out_lvl_q;
	logic [FACE_W-1:0]    out_face_q;

	logic [ADDR_BITS-1:0] in_base, in_surf;
	logic [LVL_W-1:0]     in_levels;
	logic                 in_fire, out_fire, out_load;
	logic [ADDR_BITS-1:0] add_a, add_b, add_sum;
	msl_size_cmd_t        cmd;
	msl_size_rsp_t        rsp;

	assign in_base   = s_axis_tdata[31:0];
	assign in_surf   = s_axis_tdata[63:32];
	assign in_levels = (s_axis_tdata[119:116] > LVL_W'(MAX_LEVELS)) ?
	                   LVL_W'(MAX_LEVELS) : s_axis_tdata[119:116];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = out_valid_q && m_axis_tready;
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_comb begin
		cmd.start  = in_fire && (in_surf != in_base) && (in_levels != '0);
		cmd.width  = s_axis_tdata[76:64];
		cmd.height = s_axis_tdata[89:77];
		cmd.depth  = s_axis_tdata[99:90];
		cmd.pitch  = s_axis_tdata[115:100];
		cmd.levels = in_levels;
		cmd.comp   = s_axis_tuser[1];
	end

	msl_size_gen u_size_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// single adder shared by accumulation, alignment, walk and face stepping
	always_comb begin
		unique case (state_q)
			ST_SIZE: begin
				add_a = total_q;
				add_b = rsp.size;
			end
			ST_STRIDE: begin
				add_a = total_q;
				add_b = ADDR_BITS'(FACE_ALIGN - 1);
			end
			ST_WALK: begin
				add_a = addr_q;
				add_b = size_mem[lvl_q];
			end
			ST_NEXTF: begin
				add_a = face_q;
				add_b = stride_q;
			end
			default: begin
				add_a = '0;
				add_b = '0;
			end
		endcase
	end
	assign add_sum = add_a + add_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) state_q <= cmd.start ? ST_SIZE : ST_DONE;
				ST_SIZE: if (rsp.valid && rsp.last) state_q <= ST_STRIDE;
				ST_STRIDE: state_q <= ST_WALK;
				ST_WALK: begin
					if (addr_q == surf_q) state_q <= ST_DONE;
					else if (lvl_q == levels_q - LVL_W'(1))
						state_q <= (fidx_q == faces_q - FACE_W'(1)) ? ST_DONE : ST_NEXTF;
				end
				ST_NEXTF: state_q <= ST_WALK;
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					base_q   <= in_base;
					surf_q   <= in_surf;
					levels_q <= in_levels;
					faces_q  <= s_axis_tuser[0] ? FACE_W'(CUBE_FACES) : FACE_W'(1);
					total_q  <= '0;
					found_q  <= (in_surf == in_base);
					lvl_q    <= '0;
					fidx_q   <= '0;
				end
			end
			ST_SIZE: begin
				if (rsp.valid) begin
					size_mem[rsp.idx] <= rsp.size;
					total_q           <= add_sum;
				end
			end
			ST_STRIDE: begin
				stride_q <= add_sum & ~ADDR_BITS'(FACE_ALIGN - 1);
				addr_q   <= base_q;
				face_q   <= base_q;
			end
			ST_WALK: begin
				if (addr_q == surf_q) begin
					found_q <= 1'b1;
				end else begin
					addr_q <= add_sum;
					lvl_q  <= lvl_q + LVL_W'(1);
				end
			end
			ST_NEXTF: begin
				face_q <= add_sum;
				addr_q <= add_sum;
				lvl_q  <= '0;
				fidx_q <= fidx_q + FACE_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= found_q;
			out_lvl_q   <= found_q ? lvl_q : '0;
			out_face_q  <= found_q ? fidx_q : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = {1'b0, out_face_q, out_lvl_q};

endmodule

`default_nettype wire

>>> rtl/msl_size_gen.sv
// Level size generator: each level passes through a two-step multiply and an emit state.
// Depends on msl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msl_size_gen
	import msl_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  msl_size_cmd_t cmd,
	output msl_size_rsp_t rsp
);

	typedef enum logic [3:0] {
		SG_IDLE = 4'b0001,
		SG_MUL1 = 4'b0010,
		SG_MUL2 = 4'b0100,
		SG_EMIT = 4'b1000
	} sg_state_t;

	sg_state_t        state_q;
	logic [DIM_W-1:0] w_q, h_q, min_q;
	logic [DEP_W-1:0] d_q;
	logic [PIT_W-1:0] p_q;
	logic [LVL_W-1:0] levels_q, idx_q;
	logic             comp_q;
	logic [PH_W-1:0]  ph_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [PROD_W+ADDR_BITS-1:0] prod_ext;
	logic [PROD_W+ADDR_BITS-1:0] prod_div;
	logic             last;

	assign last     = (idx_q == levels_q - LVL_W'(1));
	assign prod_ext = {{ADDR_BITS{1'b0}}, prod_s2};
	assign prod_div = comp_q ? (prod_ext >> BLOCK_DIV_LG) : prod_ext;

	always_comb begin
		rsp.valid = (state_q == SG_EMIT);
		rsp.last  = last;
		rsp.idx   = idx_q;
		rsp.size  = prod_div[ADDR_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SG_IDLE;
		end else begin
			unique case (state_q)
				SG_IDLE: if (cmd.start) state_q <= SG_MUL1;
				SG_MUL1: state_q <= SG_MUL2;
				SG_MUL2: state_q <= SG_EMIT;
				SG_EMIT: state_q <= last ? SG_IDLE : SG_MUL1;
				default: state_q <= SG_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			SG_IDLE: begin
				if (cmd.start) begin
					w_q      <= cmd.width;
					h_q      <= cmd.height;
					d_q      <= cmd.depth;
					p_q      <= cmd.pitch;
					levels_q <= cmd.levels;
					comp_q   <= cmd.comp;
					min_q    <= cmd.comp ? DIM_W'(BLOCK_MIN) : DIM_W'(1);
					idx_q    <= '0;
				end
			end
			SG_MUL1: ph_s1 <= PH_W'(p_q) * PH_W'(h_q);
			SG_MUL2: prod_s2 <= PROD_W'(ph_s1) * PROD_W'(d_q);
			SG_EMIT: begin
				// width and pitch halve together
				if (w_q > min_q) begin
					w_q <= w_q >> 1;
					p_q <= p_q >> 1;
				end
				if (h_q > min_q) h_q <= h_q >> 1;
				if (d_q > DEP_W'(1)) d_q <= d_q >> 1;
				idx_q <= idx_q + LVL_W'(1);
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/msl_checker.sv
// Port-level checks for mip_surface_locator, bound to the top level.
// Depends on mip_surface_locator's port list only.
`timescale 1ns / 1ps
`default_nettype none

module msl_port_checks (
	input wire         clk,
	input wire         arst_n,
	input wire         s_axis_tvalid,
	input wire         s_axis_tready,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [7:0]   m_axis_tdata,
	input wire         m_axis_tuser
);

	// one lookup at a time: the input closes right after a transaction
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a lookup is in flight");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// a miss reports level 0, face 0
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)
		else $error("miss with nonzero level or face");

	// face index stays within a cube, level index below 15
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[6:4] != 3'd6 && m_axis_tdata[6:4] != 3'd7
		&& m_axis_tdata[3:0] != 4'd15)
		else $error("face or level index out of range");

endmodule

bind mip_surface_locator msl_port_checks u_msl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> tb/msl_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the mip surface locator: watches both stream channels, predicts each result.
// Needs nothing but the channel signals; no package types are used.

module msl_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tready,
	// texture_base, surface_addr, base_width, base_height, base_depth, base_pitch, level_count
	input  wire [119:0] s_axis_tdata,
	// is_cube, is_compressed
	input  wire [1:0]   s_axis_tuser,
	input  wire         m_axis_tvalid,
	input  wire         m_axis_tready,
	// level_index, face_index, zero
	input  wire [7:0]   m_axis_tdata,
	// found
	input  wire         m_axis_tuser,
	output int          mismatches,
	output int          pending,
	output int          lookups_done,
	output int          hits,
	output int          far_face_hits,
	output int          deepest_hit
);

	localparam int STRIDE_ALIGN = 128;
	localparam int LEVEL_CAP    = 15;
	localparam int FACES_CUBE   = 6;
	localparam int COMP_MIN     = 4;
	localparam int PRINT_CAP    = 100;

	typedef struct packed {
		logic       found;
		logic [3:0] level;
		logic [2:0] face;
	} surface_loc_t;

	surface_loc_t awaited_loc[$];

	// walk faces then levels; first level start equal to the surface address wins
	function automatic surface_loc_t locate_surface(input logic [119:0] d, input logic [1:0] u);
		logic [31:0] base, surf, addr;
		logic [63:0] w, h, dep, p, min_dim, total, stride;
		logic [63:0] lvl_size [LEVEL_CAP];
		int nlev, nface;
		logic comp;
		surface_loc_t loc;
		loc = '0;
		base = d[31:0];
		surf = d[63:32];
		w = 64'(d[76:64]);
		h = 64'(d[89:77]);
		dep = 64'(d[99:90]);
		p = 64'(d[115:100]);
		nlev = int'(d[119:116]);
		comp = u[1];
		nface = u[0] ? FACES_CUBE : 1;
		if (surf == base) begin
			loc.found = 1'b1;
			return loc;
		end
		if (nlev > LEVEL_CAP)
			nlev = LEVEL_CAP;
		min_dim = comp ? 64'(COMP_MIN) : 64'd1;
		total = '0;
		for (int l = 0; l < nlev; l++) begin
			lvl_size[l] = p * h * dep;
			if (comp)
				lvl_size[l] = lvl_size[l] >> 2;
			total += lvl_size[l];
			if (w > min_dim) begin
				w = w >> 1;
				p = p >> 1;
			end
			if (h > min_dim)
				h = h >> 1;
			if (dep > 64'd1)
				dep = dep >> 1;
		end
		stride = (total + 64'(STRIDE_ALIGN - 1)) / 64'(STRIDE_ALIGN) * 64'(STRIDE_ALIGN);
		for (int f = 0; f < nface; f++) begin
			addr = 32'(64'(base) + 64'(f) * stride);
			for (int l = 0; l < nlev; l++) begin
				if (addr == surf) begin
					loc.found = 1'b1;
					loc.level = 4'(l);
					loc.face  = 3'(f);
					return loc;
				end
				addr = addr + lvl_size[l][31:0];
			end
		end
		return loc;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_CAP)
			$display("msl_checker: result %0d: %s is %0d, expected %0d",
				lookups_done, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : watch
		surface_loc_t want;
		if (!arst_n) begin
			awaited_loc.delete();
			pending = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				awaited_loc.push_back(locate_surface(s_axis_tdata, s_axis_tuser));
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_loc.size() == 0) begin
					report_mismatch("unsolicited result, found", int'(m_axis_tuser), 0);
				end else begin
					want = awaited_loc.pop_front();
					if (m_axis_tuser !== want.found)
						report_mismatch("found", int'(m_axis_tuser), int'(want.found));
					if (m_axis_tdata[3:0] !== want.level)
						report_mismatch("level_index", int'(m_axis_tdata[3:0]),
							int'(want.level));
					if (m_axis_tdata[6:4] !== want.face)
						report_mismatch("face_index", int'(m_axis_tdata[6:4]),
							int'(want.face));
					if (want.found) begin
						hits++;
						if (want.face != 0)
							far_face_hits++;
						if (int'(want.level) > deepest_hit)
							deepest_hit = int'(want.level);
					end
				end
				lookups_done++;
			end
			pending = awaited_loc.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for mip_surface_locator: clock, reset, lookup stimulus and verdict.
// Depends on the RTL block and on msl_checker, which predicts and compares.

module tb_top;

	localparam int RANDOM_LOOKUPS = 1830;
	localparam int DRAIN_LIMIT    = 4000;
	localparam int TAIL_CYCLES    = 160;

	// packs straight onto {s_axis_tuser, s_axis_tdata}
	typedef struct packed {
		logic        comp;
		logic        cube;
		logic [3:0]  levels;
		logic [15:0] pitch;
		logic [9:0]  depth;
		logic [12:0] height;
		logic [12:0] width;
		logic [31:0] surf;
		logic [31:0] base;
	} lookup_req_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	wire          s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	wire          m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	wire  [7:0]   m_axis_tdata;
	wire          m_axis_tuser;

	int chk_errors, chk_pending, chk_results, chk_hits, chk_far_faces, chk_deepest;

	int stall_mode = 0;
	int stall_left = 0;

	always #4 clk = ~clk;

	mip_surface_locator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	msl_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (chk_errors),
		.pending       (chk_pending),
		.lookups_done  (chk_results),
		.hits          (chk_hits),
		.far_face_hits (chk_far_faces),
		.deepest_hit   (chk_deepest)
	);

	// receiver: switches between always ready, coin flip, mostly stalled and a fixed rhythm
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 7) == 0);
			default: m_axis_tready <= (stall_left % 3 != 0);
		endcase
	end

	// start address of (face, level); a level past the count lands at the end of the face
	function automatic logic [31:0] level_start(input lookup_req_t r, input int face,
		input int level);
		logic [63:0] w, h, dep, p, lsz, min_dim, face_sum, up_to, stride;
		w = 64'(r.width);
		h = 64'(r.height);
		dep = 64'(r.depth);
		p = 64'(r.pitch);
		min_dim = r.comp ? 64'd4 : 64'd1;
		face_sum = '0;
		up_to = '0;
		for (int l = 0; l < int'(r.levels); l++) begin
			lsz = p * h * dep;
			if (r.comp)
				lsz = lsz >> 2;
			if (l < level)
				up_to += lsz;
			face_sum += lsz;
			if (w > min_dim) begin
				w = w >> 1;
				p = p >> 1;
			end
			if (h > min_dim)
				h = h >> 1;
			if (dep > 64'd1)
				dep = dep >> 1;
		end
		stride = (face_sum + 64'd127) & ~64'd127;
		return 32'(64'(r.base) + 64'(face) * stride + up_to);
	endfunction

	function automatic lookup_req_t texture(input logic [31:0] base, input int w, input int h,
		input int d, input int p, input int lv, input bit cube, input bit comp);
		lookup_req_t r;
		r.base = base;
		r.surf = base;
		r.width = 13'(w);
		r.height = 13'(h);
		r.depth = 10'(d);
		r.pitch = 16'(p);
		r.levels = 4'(lv);
		r.cube = cube;
		r.comp = comp;
		return r;
	endfunction

	// mostly small textures aimed at a real level start; some near misses and noise
	function automatic lookup_req_t rand_lookup();
		lookup_req_t r;
		int pick, fsel, lsel;
		logic [31:0] aim, off;
		r.base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 4095))
			: 32'($urandom);
		pick = $urandom_range(0, 9);
		r.width = (pick < 7) ? 13'($urandom_range(1, 64)) :
			(pick < 9) ? 13'($urandom_range(1, 4096)) : 13'($urandom_range(0, 8191));
		pick = $urandom_range(0, 9);
		r.height = (pick < 7) ? 13'($urandom_range(1, 64)) :
			(pick < 9) ? 13'($urandom_range(1, 4096)) : 13'($urandom_range(0, 8191));
		pick = $urandom_range(0, 9);
		r.depth = (pick < 6) ? 10'd1 :
			(pick < 9) ? 10'($urandom_range(1, 16)) : 10'($urandom_range(0, 1023));
		pick = $urandom_range(0, 9);
		r.pitch = (pick < 8) ? 16'($urandom_range(1, 512)) : 16'($urandom_range(0, 65535));
		r.levels = ($urandom_range(0, 15) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
		r.cube = 1'($urandom_range(0, 1));
		r.comp = 1'($urandom_range(0, 1));
		fsel = r.cube ? $urandom_range(0, 5) : 0;
		lsel = (r.levels == 0) ? 0 : $urandom_range(0, int'(r.levels) - 1);
		aim = level_start(r, fsel, lsel);
		off = 32'($urandom_range(1, 256));
		pick = $urandom_range(0, 19);
		if (pick < 12)
			r.surf = aim;
		else if (pick < 14)
			r.surf = r.base;
		else if (pick < 16)
			r.surf = $urandom_range(0, 1) ? aim + off : aim - off;
		else if (pick < 18)
			r.surf = level_start(r, r.cube ? 6 : 1, 0);
		else
			r.surf = 32'($urandom);
		return r;
	endfunction

	task automatic send_lookup(input lookup_req_t r);
		@(negedge clk);
		s_axis_tdata  <= r[119:0];
		s_axis_tuser  <= r[121:120];
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// idle gap with junk on the data lines
	task automatic pause(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 120'({$urandom, $urandom, $urandom, $urandom});
			s_axis_tuser  <= 2'($urandom_range(0, 3));
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (chk_pending != 0) @(negedge clk);
	endtask

	initial begin
		#12_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		lookup_req_t t;
		int sent, burst, gap, waited;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero level count: only the base matches
		t = texture(32'h1000_0000, 16, 16, 1, 64, 0, 1'b0, 1'b0);
		send_lookup(t);
		t.surf = t.base + 32'd64;
		send_lookup(t);
		// largest legal texture, last level of the last face
		t = texture(32'h0, 4096, 4096, 512, 65535, 15, 1'b1, 1'b1);
		t.surf = level_start(t, 5, 14);
		send_lookup(t);
		// every field but the compressed flag all ones, addresses wrap
		t = texture(32'hFFFF_FFFF, 8191, 8191, 1023, 65535, 15, 1'b1, 1'b0);
		t.surf = level_start(t, 3, 7);
		send_lookup(t);
		pause($urandom_range(0, 3));
		// zero dimensions: every level has zero size
		t = texture(32'h0000_2000, 0, 0, 0, 0, 15, 1'b1, 1'b0);
		t.surf = t.base + 32'd128;
		send_lookup(t);
		t.surf = t.base;
		send_lookup(t);
		t = texture(32'h0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
		send_lookup(t);
		t.surf = 32'hFFFF_FFFF;
		t.levels = 4'd15;
		send_lookup(t);
		// face stride crosses the top of the address space
		t = texture(32'hFFFF_FF80, 8, 8, 1, 32, 4, 1'b1, 1'b0);
		t.surf = level_start(t, 2, 1);
		send_lookup(t);
		pause($urandom_range(0, 3));
		// second face start on a single-face texture
		t = texture(32'h0000_4000, 32, 32, 1, 128, 6, 1'b0, 1'b0);
		t.surf = level_start(t, 1, 0);
		send_lookup(t);
		// compressed at and below the minimum block size
		t = texture(32'h0000_8000, 4, 4, 1, 16, 5, 1'b0, 1'b1);
		t.surf = level_start(t, 0, 3);
		send_lookup(t);
		t = texture(32'h0000_8000, 2, 2, 1, 3, 3, 1'b1, 1'b1);
		t.surf = level_start(t, 1, 1);
		send_lookup(t);
		t = texture(32'h1234_5600, 4096, 1, 1, 16384, 15, 1'b0, 1'b0);
		t.surf = level_start(t, 0, 14);
		send_lookup(t);
		pause($urandom_range(0, 3));
		t = texture(32'h0010_0000, 64, 64, 4, 256, 7, 1'b1, 1'b0);
		t.surf = level_start(t, 5, 6);
		send_lookup(t);
		t.surf = level_start(t, 0, 7);
		send_lookup(t);
		t.surf = level_start(t, 2, 3) + 32'd1;
		send_lookup(t);
		// deep texture, depth keeps halving
		t = texture(32'h0000_0040, 16, 16, 512, 64, 10, 1'b0, 1'b0);
		t.surf = level_start(t, 0, 9);
		send_lookup(t);
		t = texture(32'hABCD_0000, 13, 7, 3, 13, 6, 1'b1, 1'b1);
		t.surf = level_start(t, 2, 5);
		send_lookup(t);
		// hold off until every directed result is back
		drain();

		sent = 0;
		while (sent < RANDOM_LOOKUPS) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < RANDOM_LOOKUPS; i++) begin
				send_lookup(rand_lookup());
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 160) : $urandom_range(0, 4);
			pause(gap);
			if ($urandom_range(0, 49) == 0)
				drain();
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (chk_pending != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (chk_pending != 0) begin
			$display("tb: failure");
			$finish;
		end else begin
			repeat (TAIL_CYCLES) @(negedge clk);
			$display("tb: %0d lookups checked, %0d hit a level start, %0d had no match",
				chk_results, chk_hits, chk_results - chk_hits);
			$display("tb: %0d hits beyond face 0, deepest level hit %0d, %0d mismatches",
				chk_far_faces, chk_deepest, chk_errors);
			if (chk_errors == 0)
				$display("tb: success");
			else
				$display("tb: failure");
			$finish;
		end
	end

endmodule
